// ===== src/mixture_component_sampler_core_assert.svh =====
// Assertion macros shared by the sampler checker.
`ifndef MIXTURE_COMPONENT_SAMPLER_CORE_ASSERT_SVH
`define MIXTURE_COMPONENT_SAMPLER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mcs_pkg.sv =====
// Package with widths, constants and elaboration-time tables of the sampler.
`default_nettype none

package mcs_pkg;

    localparam int MAX_COMP_DEF = 16;
    localparam int NC_W         = 5;
    localparam int COMP_W       = 5;
    localparam int IDX_W        = 4;
    localparam int Q24_W        = 24;
    localparam int SD_W         = 20;
    localparam int CUM_W        = 36;
    localparam int DENS_W       = 32;
    localparam int ADDR_W       = 3;

    localparam logic [NC_W-1:0]   NC_RESET  = 5'd10;
    localparam logic              REG_NUM_COMPONENTS = 1'b0;
    localparam logic [31:0]       LN2_Q30   = 32'd744261118;
    localparam logic [31:0]       LOG2E_Q30 = 32'd1549082005;
    localparam logic [DENS_W-1:0] DENS_MAX  = 32'hFFFF_FFFF;
    localparam logic [CUM_W-1:0]  CUM_MAX   = 36'hF_FFFF_FFFF;
    localparam logic [23:0]       MASK24    = 24'hFF_FFFF;

    typedef struct packed {
        logic [4:0]  p;
        logic [30:0] mm;
    } norm_t;

    typedef logic [15:0][30:0] fac_tab_t;

    // Leading-one position and mantissa aligned to Q.30.
    function automatic norm_t log_norm(input logic [23:0] v);
        norm_t       n;
        logic [54:0] sh;
        n.p = 5'd0;
        for (int i = 0; i < 24; i++)
        begin
            if (v[i])
            begin
                n.p = 5'(i);
            end
        end
        sh   = 55'(v) << (5'd30 - n.p);
        n.mm = sh[30:0];
        return n;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] rem;
        r   = 64'd0;
        rem = v;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (b > rem)
            begin
                b = b >> 2;
            end
        end
        for (int i = 0; i < 32; i++)
        begin
            if (b != 64'd0)
            begin
                if (rem >= r + b)
                begin
                    rem = rem - (r + b);
                    r   = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Factors 2^(2^-i), i = 1..16, in Q.30 by repeated square roots.
    function automatic fac_tab_t build_exp_factors();
        fac_tab_t    t;
        logic [63:0] c;
        c = 64'd1 << 31;
        for (int i = 0; i < 16; i++)
        begin
            c    = isqrt64(c << 30);
            t[i] = c[30:0];
        end
        return t;
    endfunction

    localparam fac_tab_t EXP_FACTORS = build_exp_factors();

endpackage

`default_nettype wire

// ===== src/mixture_component_sampler_core.sv =====
// Top level of the mixture component sampler: sequencer around one shared multiplier.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one transaction per item. req_type 0
//   loads a component slot (weight, mean, std_dev); req_type 1 samples one residual
//   with its uniform fraction and produces one result transaction on the output
//   channel (out_valid / out_stall): the 1-based component, no_mass and last_out.
//   Load items produce no result.
//   A load runs two 16-step log2 squarings, a 33-step restoring divide for 1/s and
//   setup states around them. A sample walks the N active components; each one
//   goes through the single 32x32 multiplier that handles the z product, the square,
//   the log2(e) scale and the 16 factor steps of the exponential; a component whose
//   exponent is out of range skips the exponential. A search over the running sums
//   then picks the component.
//   in_stall is high for the whole item; the block takes one item at a time.
//   The result sits in an output register: a new item is accepted while it waits,
//   and only the final hand-off of the next result waits for the receiver.
//   Reset: the sequencer goes idle, no result is pending, num_components becomes
//   10. Component tables are not cleared and must be loaded before use.
`default_nettype none

module mixture_component_sampler_core #(
    parameter int MAX_COMPONENTS = mcs_pkg::MAX_COMP_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mcs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // input channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       req_type,
    input  logic [mcs_pkg::IDX_W-1:0]  entry_index,
    input  logic [mcs_pkg::Q24_W-1:0]  weight,
    input  logic signed [mcs_pkg::Q24_W-1:0] mean,
    input  logic [mcs_pkg::SD_W-1:0]   std_dev,
    input  logic signed [mcs_pkg::Q24_W-1:0] residual,
    input  logic [mcs_pkg::Q24_W-1:0]  uniform,
    input  logic                       last_in,
    // output channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [mcs_pkg::COMP_W-1:0] component,
    output logic                       no_mass,
    output logic                       last_out
);

    import mcs_pkg::*;

    localparam int AW    = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int CNT_W = $clog2(MAX_COMPONENTS + 1);

    typedef enum logic [20:0] {
        ST_IDLE    = 21'h000001,
        ST_LD_INIT = 21'h000002,
        ST_LD_LOG  = 21'h000004,
        ST_LD_LN   = 21'h000008,
        ST_LD_LC   = 21'h000010,
        ST_LD_DIV  = 21'h000020,
        ST_LD_WR   = 21'h000040,
        ST_SM_INIT = 21'h000080,
        ST_SM_RD   = 21'h000100,
        ST_SM_Z    = 21'h000200,
        ST_SM_SQ   = 21'h000400,
        ST_SM_A    = 21'h000800,
        ST_SM_K    = 21'h001000,
        ST_SM_EXP  = 21'h002000,
        ST_SM_SH   = 21'h004000,
        ST_SM_ACC  = 21'h008000,
        ST_SM_U0   = 21'h010000,
        ST_SM_U1   = 21'h020000,
        ST_SM_U2   = 21'h040000,
        ST_SM_SRCH = 21'h080000,
        ST_OUT     = 21'h100000
    } state_t;

    localparam logic signed [29:0] A_LOW  = -30'sd1114112;   // -17.0 in Q.16
    localparam logic signed [29:0] A_HIGH = 30'sd393216;     // 6.0 in Q.16
    localparam logic [53:0]        RND30  = 54'h3FFF_FFFF;

    // ---------------- registers ----------------
    state_t             st_reg, st_next;
    logic [NC_W-1:0]    nc_reg, nc_next;
    logic               out_valid_reg, out_valid_next;
    logic [5:0]         it_reg, it_next;
    logic               ph_reg, ph_next;
    logic               sel_reg, sel_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic [23:0]        w_reg, w_next;
    logic [19:0]        s_reg, s_next;
    logic [23:0]        mean_in_reg, mean_in_next;
    logic [3:0]         idx_reg, idx_next;
    logic [23:0]        x_reg, x_next;
    logic [23:0]        uni_reg, uni_next;
    logic               last_reg, last_next;
    logic [30:0]        mm_reg, mm_next;
    logic [15:0]        f_reg, f_next;
    logic [4:0]         p_reg, p_next;
    logic [20:0]        lw_reg, lw_next;
    logic               neg_reg, neg_next;
    logic [23:0]        lc_reg, lc_next;
    logic [19:0]        rem_reg, rem_next;
    logic [32:0]        q_reg, q_next;
    logic [CUM_W-1:0]   total_reg, total_next;
    logic [DENS_W-1:0]  dens_reg, dens_next;
    logic [7:0]         k_reg, k_next;
    logic [15:0]        frac_reg, frac_next;
    logic [41:0]        lo_reg, lo_next;
    logic [CUM_W-1:0]   u_reg, u_next;
    logic               nomass_reg, nomass_next;
    logic [COMP_W-1:0]  comp_reg, comp_next;
    logic               nomass_out_reg, nomass_out_next;
    logic               last_out_reg, last_out_next;
    logic [63:0]        prod_reg;

    // shared multiplier operands
    logic [31:0]        mul_a, mul_b;

    // component parameter store {log coef, mean, 1/s} and running sums
    logic [71:0]        prm_mem [MAX_COMPONENTS];
    logic [71:0]        prm_rd;
    logic               prm_we;
    logic [CUM_W-1:0]   cum_mem [MAX_COMPONENTS];
    logic [CUM_W-1:0]   cum_rd;
    logic               cum_we;
    logic [AW-1:0]      cum_raddr;
    logic [AW-1:0]      jidx;

    // ---------------- datapath terms ----------------
    logic               in_acc, out_acc, out_free, cfg_wr;
    norm_t              norm_w, norm_s;
    logic [23:0]        w_cl;
    logic [19:0]        s_cl;
    logic [31:0]        sq_t;
    logic [30:0]        sq_mm;
    logic [15:0]        sq_f;
    logic signed [22:0] l2_val;
    logic [22:0]        l2_abs;
    logic [53:0]        lc_rnd;
    logic [23:0]        lc_val;
    logic [20:0]        rem_sh;
    logic               div_ge;
    logic [23:0]        inv_val;
    logic signed [24:0] d_val;
    logic [24:0]        ad_val;
    logic [47:0]        pz_val;
    logic [22:0]        zq_val;
    logic [27:0]        q_val;
    logic signed [29:0] a_val;
    logic [29:0]        a_abs;
    logic [53:0]        y_rnd;
    logic [23:0]        f_val;
    logic               exp_bit;
    logic signed [8:0]  sh_val;
    logic [8:0]         nsh_val;
    logic [39:0]        shl_val;
    logic [31:0]        dens_val;
    logic [36:0]        acc_sum;
    logic [CUM_W-1:0]   acc_val;
    logic [59:0]        u_sum;
    logic [CNT_W-1:0]   cnt_val;

    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;

    assign jidx = j_reg[AW-1:0];

    // load side: log2 normalization and squaring step
    assign w_cl   = (w_reg == 24'd0) ? 24'd1 : w_reg;
    assign s_cl   = (s_reg == 20'd0) ? 20'd1 : s_reg;
    assign norm_w = log_norm(w_cl);
    assign norm_s = log_norm(24'(s_cl));
    assign sq_t   = prod_reg[61:30];
    assign sq_mm  = sq_t[31] ? sq_t[31:1] : sq_t[30:0];
    assign sq_f   = {f_reg[14:0], sq_t[31]};
    assign l2_val = $signed({2'b00, lw_reg}) - $signed({2'b00, p_reg, sq_f})
                    - 23'sd524288;
    assign l2_abs = l2_val[22] ? 23'(-l2_val) : 23'(l2_val);

    // floor(l2 * ln2 / 2^30) from the magnitude product
    assign lc_rnd = (54'(prod_reg[51:0]) + RND30) >> 30;
    assign lc_val = neg_reg ? 24'(-lc_rnd[23:0]) : prod_reg[53:30];

    // restoring divide of 2^32 by s, one quotient bit per cycle
    assign rem_sh  = {rem_reg, (it_reg == 6'd0)};
    assign div_ge  = rem_sh >= {1'b0, s_cl};
    assign inv_val = (q_reg > {9'd0, MASK24}) ? MASK24 : q_reg[23:0];

    // sample side
    assign d_val  = $signed({x_reg[23], x_reg}) - $signed({prm_rd[47], prm_rd[47:24]});
    assign ad_val = d_val[24] ? 25'(-d_val) : 25'(d_val);
    assign pz_val = prod_reg[63:16];
    assign zq_val = (pz_val > 48'h40_0000) ? 23'h40_0000 : pz_val[22:0];
    assign q_val  = prod_reg[44:17];
    assign a_val  = 30'($signed(prm_rd[71:48])) - $signed({2'b00, q_val});
    assign a_abs  = a_val[29] ? 30'(-a_val) : 30'(a_val);
    assign y_rnd  = (54'(prod_reg[52:0]) + RND30) >> 30;
    assign f_val  = neg_reg ? 24'(-y_rnd[23:0]) : {1'b0, prod_reg[52:30]};
    assign exp_bit = frac_reg[4'd15 - it_reg[3:0]];

    // scale 2^frac by 2^(k-6) into Q8.24
    assign sh_val  = $signed({k_reg[7], k_reg}) - 9'sd6;
    assign nsh_val = 9'(-sh_val);
    assign shl_val = 40'(mm_reg) << sh_val[3:0];

    always_comb
    begin
        if (!sh_val[8])
        begin
            if (sh_val > 9'sd8)
            begin
                dens_val = DENS_MAX;
            end
            else if (shl_val > 40'(DENS_MAX))
            begin
                dens_val = DENS_MAX;
            end
            else
            begin
                dens_val = shl_val[31:0];
            end
        end
        else if (nsh_val > 9'd31)
        begin
            dens_val = 32'd0;
        end
        else
        begin
            dens_val = 32'(mm_reg >> nsh_val[4:0]);
        end
    end

    assign acc_sum = 37'(total_reg) + 37'(dens_reg);
    assign acc_val = acc_sum[36] ? CUM_MAX : acc_sum[35:0];
    assign u_sum   = {prod_reg[41:0], 18'd0} + 60'(lo_reg);

    always_comb
    begin
        if (nc_reg == '0)
        begin
            cnt_val = CNT_W'(1);
        end
        else if (int'(nc_reg) > MAX_COMPONENTS)
        begin
            cnt_val = CNT_W'(MAX_COMPONENTS);
        end
        else
        begin
            cnt_val = CNT_W'(nc_reg);
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        st_next         = st_reg;
        nc_next         = nc_reg;
        out_valid_next  = out_valid_reg;
        it_next         = it_reg;
        ph_next         = ph_reg;
        sel_next        = sel_reg;
        j_next          = j_reg;
        cnt_next        = cnt_reg;
        w_next          = w_reg;
        s_next          = s_reg;
        mean_in_next    = mean_in_reg;
        idx_next        = idx_reg;
        x_next          = x_reg;
        uni_next        = uni_reg;
        last_next       = last_reg;
        mm_next         = mm_reg;
        f_next          = f_reg;
        p_next          = p_reg;
        lw_next         = lw_reg;
        neg_next        = neg_reg;
        lc_next         = lc_reg;
        rem_next        = rem_reg;
        q_next          = q_reg;
        total_next      = total_reg;
        dens_next       = dens_reg;
        k_next          = k_reg;
        frac_next       = frac_reg;
        lo_next         = lo_reg;
        u_next          = u_reg;
        nomass_next     = nomass_reg;
        comp_next       = comp_reg;
        nomass_out_next = nomass_out_reg;
        last_out_next   = last_out_reg;
        mul_a           = 32'd0;
        mul_b           = 32'd0;
        prm_we          = 1'b0;
        cum_we          = 1'b0;
        cum_raddr       = jidx;

        if (cfg_wr && (paddr[2] == REG_NUM_COMPONENTS))
        begin
            nc_next = pwdata[NC_W-1:0];
        end

        // drop the pending result once the receiver takes it
        if (out_acc)
        begin
            out_valid_next = 1'b0;
        end

        unique case (st_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    w_next       = weight;
                    s_next       = std_dev;
                    mean_in_next = mean;
                    idx_next     = entry_index;
                    x_next       = residual;
                    uni_next     = uniform;
                    last_next    = last_in;
                    st_next      = req_type ? ST_SM_INIT : ST_LD_INIT;
                end
            end

            ST_LD_INIT:
            begin
                mm_next  = norm_w.mm;
                p_next   = norm_w.p;
                f_next   = 16'd0;
                it_next  = 6'd0;
                ph_next  = 1'b0;
                sel_next = 1'b0;
                st_next  = ST_LD_LOG;
            end

            ST_LD_LOG:
            begin
                mul_a = 32'(mm_reg);
                mul_b = 32'(mm_reg);
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    ph_next = 1'b0;
                    mm_next = sq_mm;
                    f_next  = sq_f;
                    it_next = it_reg + 6'd1;
                    if (it_reg == 6'd15)
                    begin
                        it_next = 6'd0;
                        if (!sel_reg)
                        begin
                            // weight done, start on std_dev
                            lw_next  = {p_reg, sq_f};
                            sel_next = 1'b1;
                            mm_next  = norm_s.mm;
                            p_next   = norm_s.p;
                            f_next   = 16'd0;
                        end
                        else
                        begin
                            neg_next = l2_val[22];
                            lw_next  = l2_abs[20:0];
                            st_next  = ST_LD_LN;
                        end
                    end
                end
            end

            ST_LD_LN:
            begin
                mul_a   = 32'(lw_reg);
                mul_b   = LN2_Q30;
                st_next = ST_LD_LC;
            end

            ST_LD_LC:
            begin
                lc_next  = lc_val;
                rem_next = 20'd0;
                q_next   = 33'd0;
                it_next  = 6'd0;
                st_next  = ST_LD_DIV;
            end

            ST_LD_DIV:
            begin
                rem_next = div_ge ? 20'(rem_sh - {1'b0, s_cl}) : rem_sh[19:0];
                q_next   = {q_reg[31:0], div_ge};
                it_next  = it_reg + 6'd1;
                if (it_reg == 6'd32)
                begin
                    st_next = ST_LD_WR;
                end
            end

            ST_LD_WR:
            begin
                prm_we  = (int'(idx_reg) < MAX_COMPONENTS);
                st_next = ST_IDLE;
            end

            ST_SM_INIT:
            begin
                cnt_next    = cnt_val;
                j_next      = '0;
                total_next  = '0;
                nomass_next = 1'b0;
                st_next     = ST_SM_RD;
            end

            ST_SM_RD:
            begin
                st_next = ST_SM_Z;
            end

            ST_SM_Z:
            begin
                mul_a   = 32'(ad_val);
                mul_b   = 32'(prm_rd[23:0]);
                st_next = ST_SM_SQ;
            end

            ST_SM_SQ:
            begin
                mul_a   = 32'(zq_val);
                mul_b   = 32'(zq_val);
                st_next = ST_SM_A;
            end

            ST_SM_A:
            begin
                mul_a    = 32'(a_abs);
                mul_b    = LOG2E_Q30;
                neg_next = a_val[29];
                if (a_val <= A_LOW)
                begin
                    dens_next = 32'd0;
                    st_next   = ST_SM_ACC;
                end
                else if (a_val >= A_HIGH)
                begin
                    dens_next = DENS_MAX;
                    st_next   = ST_SM_ACC;
                end
                else
                begin
                    st_next = ST_SM_K;
                end
            end

            ST_SM_K:
            begin
                k_next    = f_val[23:16];
                frac_next = f_val[15:0];
                mm_next   = 31'h4000_0000;
                it_next   = 6'd0;
                ph_next   = 1'b0;
                st_next   = ST_SM_EXP;
            end

            ST_SM_EXP:
            begin
                mul_a = 32'(mm_reg);
                mul_b = 32'(EXP_FACTORS[it_reg[3:0]]);
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    ph_next = 1'b0;
                    if (exp_bit)
                    begin
                        mm_next = prod_reg[60:30];
                    end
                    it_next = it_reg + 6'd1;
                    if (it_reg == 6'd15)
                    begin
                        st_next = ST_SM_SH;
                    end
                end
            end

            ST_SM_SH:
            begin
                dens_next = dens_val;
                st_next   = ST_SM_ACC;
            end

            ST_SM_ACC:
            begin
                total_next = acc_val;
                cum_we     = 1'b1;
                if (j_reg == cnt_reg - CNT_W'(1))
                begin
                    st_next = ST_SM_U0;
                end
                else
                begin
                    j_next  = j_reg + CNT_W'(1);
                    st_next = ST_SM_RD;
                end
            end

            ST_SM_U0:
            begin
                mul_a = 32'(uni_reg);
                mul_b = 32'(total_reg[17:0]);
                if (total_reg == '0)
                begin
                    nomass_next = 1'b1;
                    j_next      = '0;
                    st_next     = ST_OUT;
                end
                else
                begin
                    st_next = ST_SM_U1;
                end
            end

            ST_SM_U1:
            begin
                lo_next = prod_reg[41:0];
                mul_a   = 32'(uni_reg);
                mul_b   = 32'(total_reg[35:18]);
                st_next = ST_SM_U2;
            end

            ST_SM_U2:
            begin
                u_next    = u_sum[59:24];
                j_next    = '0;
                cum_raddr = '0;
                st_next   = ST_SM_SRCH;
            end

            ST_SM_SRCH:
            begin
                cum_raddr = AW'(j_reg + CNT_W'(1));
                if ((j_reg == cnt_reg - CNT_W'(1)) || (cum_rd >= u_reg))
                begin
                    st_next = ST_OUT;
                end
                else
                begin
                    j_next = j_reg + CNT_W'(1);
                end
            end

            ST_OUT:
            begin
                // hold here until the output register is free
                if (out_free)
                begin
                    comp_next       = COMP_W'({1'b0, j_reg} + (CNT_W + 1)'(1));
                    nomass_out_next = nomass_reg;
                    last_out_next   = last_reg;
                    out_valid_next  = 1'b1;
                    st_next         = ST_IDLE;
                end
            end

            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            nc_reg        <= NC_RESET;
            out_valid_reg <= 1'b0;
            it_reg        <= 6'd0;
            ph_reg        <= 1'b0;
            sel_reg       <= 1'b0;
            j_reg         <= '0;
            cnt_reg       <= CNT_W'(1);
        end
        else
        begin
            st_reg        <= st_next;
            nc_reg        <= nc_next;
            out_valid_reg <= out_valid_next;
            it_reg        <= it_next;
            ph_reg        <= ph_next;
            sel_reg       <= sel_next;
            j_reg         <= j_next;
            cnt_reg       <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        w_reg          <= w_next;
        s_reg          <= s_next;
        mean_in_reg    <= mean_in_next;
        idx_reg        <= idx_next;
        x_reg          <= x_next;
        uni_reg        <= uni_next;
        last_reg       <= last_next;
        mm_reg         <= mm_next;
        f_reg          <= f_next;
        p_reg          <= p_next;
        lw_reg         <= lw_next;
        neg_reg        <= neg_next;
        lc_reg         <= lc_next;
        rem_reg        <= rem_next;
        q_reg          <= q_next;
        total_reg      <= total_next;
        dens_reg       <= dens_next;
        k_reg          <= k_next;
        frac_reg       <= frac_next;
        lo_reg         <= lo_next;
        u_reg          <= u_next;
        nomass_reg     <= nomass_next;
        comp_reg       <= comp_next;
        nomass_out_reg <= nomass_out_next;
        last_out_reg   <= last_out_next;
        prod_reg       <= 64'(mul_a) * 64'(mul_b);
    end

    // parameter store: written by loads, read at the current component
    always_ff @(posedge clk)
    begin
        if (prm_we)
        begin
            prm_mem[AW'(idx_reg)] <= {lc_reg, mean_in_reg, inv_val};
        end
        prm_rd <= prm_mem[jidx];
    end

    // running sums: written during the walk, read during the search
    always_ff @(posedge clk)
    begin
        if (cum_we)
        begin
            cum_mem[jidx] <= acc_val;
        end
        cum_rd <= cum_mem[cum_raddr];
    end

    // ---------------- ports ----------------
    assign in_stall  = (st_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign component = comp_reg;
    assign no_mass   = nomass_out_reg;
    assign last_out  = last_out_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_NUM_COMPONENTS) ? 32'(nc_reg) : 32'd0;

endmodule

`default_nettype wire

// ===== src/mcs_checker.sv =====
// Port-level checker for the mixture component sampler, bound to the top level.
`default_nettype none

`include "mixture_component_sampler_core_assert.svh"

module mcs_checker #(
    parameter int MAX_COMPONENTS = mcs_pkg::MAX_COMP_DEF
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [mcs_pkg::COMP_W-1:0] component,
    input logic                       no_mass
);

    import mcs_pkg::*;

    localparam bit WRAPS = (MAX_COMPONENTS >= (1 << COMP_W));

    // a stalled result stays offered
    `MCS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

    // an accepted item keeps the block busy for the next cycle
    `MCS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "block idle after accept")

    // empty mixture mass always reports the first component
    `MCS_ASSERT_NOW(a_nomass_first, out_valid && no_mass, component == COMP_W'(1), "no_mass with component other than 1")

    // drawn component lies in 1..MAX_COMPONENTS, unless that range overflows the component width
    `MCS_ASSERT_NOW(a_comp_range, out_valid, WRAPS || ((component != '0) && (int'(component) <= MAX_COMPONENTS)), "component out of range")

endmodule

bind mixture_component_sampler_core mcs_checker #(
    .MAX_COMPONENTS(MAX_COMPONENTS)
) u_mcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .component (component),
    .no_mass   (no_mass)
);

`default_nettype wire
